// File: rtl/core/spq_pkg.sv
`default_nettype none

package spq_pkg;

   // Field widths of the channels
   localparam int HANDLE_W = 16;
   localparam int PRIO_W   = 3;
   localparam int MAXCNT_W = 7;

   // Defaults for the top-level parameters
   localparam int DEFAULT_QUEUE_DEPTH     = 8;
   localparam int DEFAULT_PRIORITY_LEVELS = 8;
   localparam int DEFAULT_HANDLE_BITS     = 16;

   // Most results one send item may produce
   localparam logic [MAXCNT_W-1:0] SEND_LIMIT = MAXCNT_W'(64);

   typedef enum logic {
      OP_RECEIVE = 1'b0,
      OP_SEND    = 1'b1
   } spq_op_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_APPEND  = 6'b000010,
      ST_THIN_RD = 6'b000100,
      ST_THIN_WR = 6'b001000,
      ST_SCAN    = 6'b010000,
      ST_READ    = 6'b100000
   } spq_state_type;

endpackage

`default_nettype wire

// File: rtl/core/spq_store.sv
`default_nettype none

module spq_store #(
   parameter int QUEUE_DEPTH     = 8,
   parameter int PRIORITY_LEVELS = 8,
   parameter int HANDLE_BITS     = 16,
   localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire logic                   wr_en,
   input  wire logic [LW-1:0]          level,
   input  wire logic [SW-1:0]          head,
   input  wire logic [SW:0]            offset,
   input  wire logic [HANDLE_BITS-1:0] wr_data,
   output logic      [HANDLE_BITS-1:0] rd_data
);

   localparam int ENTRIES = PRIORITY_LEVELS * QUEUE_DEPTH;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [HANDLE_BITS-1:0] mem [ENTRIES];
   logic [HANDLE_BITS-1:0] rd_data_ff;
   logic [SW:0]            sum;
   logic [SW-1:0]          slot;
   logic [AW-1:0]          addr;

   // Wrap head plus offset around the ring of this level; the sum stays below twice the depth
   always_comb begin
      sum  = (SW + 1)'(head) + offset;
      if (sum >= (SW + 1)'(QUEUE_DEPTH)) begin
         slot = SW'(sum - (SW + 1)'(QUEUE_DEPTH));
      end else begin
         slot = SW'(sum);
      end
      addr = AW'(level) * AW'(QUEUE_DEPTH) + AW'(slot);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/strict_priority_packet_queue.sv
// Strict-priority packet queue: one ring of packet handles per priority level,
// all held in one synchronous memory with a registered read.
//
// Request channel (req_): opcode receive appends req_packet_handle to the ring of
// req_priority_req; a level beyond the configured levels is ignored. A receive
// into a full level first drops every second stored item, then appends.
// Opcode send emits up to req_max_count handles (saturated at 64), highest
// level first and in arrival order within a level, each removed as it goes.
//
// Result channel (rsp_): one item per emitted handle, rsp_last on the final one.
// A send with nothing to emit, or with max_count zero, gives no result.
//
// Sequence: a receive ends in an append, preceded when the level is full by a
// memory read-then-write for each kept item moved down. A send that emits
// nothing returns to idle from the scan; otherwise it steps past empty levels,
// and per emitted handle reads the memory, then loads the output register.
// req_ready is high only between items. The output register holds a result while
// rsp_ready is low; the next receive may proceed meanwhile, and a send waits at
// each handle until the register frees. Reset empties every level at once.
`default_nettype none

module strict_priority_packet_queue #(
   parameter int QUEUE_DEPTH     = spq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PRIORITY_LEVELS = spq_pkg::DEFAULT_PRIORITY_LEVELS,
   parameter int HANDLE_BITS     = spq_pkg::DEFAULT_HANDLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [spq_pkg::HANDLE_W-1:0]  req_packet_handle,
   input  wire logic [spq_pkg::PRIO_W-1:0]    req_priority_req,
   input  wire logic [spq_pkg::MAXCNT_W-1:0]  req_max_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [spq_pkg::HANDLE_W-1:0]  rsp_sent_handle,
   output logic      [spq_pkg::PRIO_W-1:0]    rsp_sent_priority,
   output logic                               rsp_last
);

   import spq_pkg::*;

   localparam int SW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int LW   = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int TW   = $clog2(PRIORITY_LEVELS * QUEUE_DEPTH + 1);
   localparam int KEEP = (QUEUE_DEPTH + 1) / 2;
   localparam int DROP = QUEUE_DEPTH / 2;

   spq_state_type          state_ff, state_in;
   logic [LW-1:0]          lvl_ff, lvl_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [MAXCNT_W-1:0]    remain_ff, remain_in;
   logic [SW-1:0]          k_ff, k_in;
   logic [CW-1:0]          count_ff [PRIORITY_LEVELS];
   logic [CW-1:0]          count_in [PRIORITY_LEVELS];
   logic [SW-1:0]          head_ff [PRIORITY_LEVELS];
   logic [SW-1:0]          head_in [PRIORITY_LEVELS];
   logic [TW-1:0]          total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]    rsp_handle_ff, rsp_handle_in;
   logic [PRIO_W-1:0]      rsp_prio_ff, rsp_prio_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   mem_rd, mem_wr;
   logic [SW:0]            mem_offset;
   logic [HANDLE_BITS-1:0] mem_wdata, mem_rdata;
   logic [LW-1:0]          req_lvl;
   logic                   req_lvl_ok;
   logic                   rsp_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_lvl    = LW'(req_priority_req);
   assign req_lvl_ok = (32'(req_priority_req) < 32'(PRIORITY_LEVELS));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      handle_in     = handle_ff;
      remain_in     = remain_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_last_in   = rsp_last_ff;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      mem_offset    = '0;
      mem_wdata     = handle_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_SEND) begin
                  remain_in = (req_max_count > SEND_LIMIT) ? SEND_LIMIT : req_max_count;
                  lvl_in    = LW'(PRIORITY_LEVELS - 1);
                  state_in  = ST_SCAN;
               end else if (req_lvl_ok) begin
                  lvl_in    = req_lvl;
                  handle_in = HANDLE_BITS'(req_packet_handle);
                  k_in      = SW'(1);
                  if (count_ff[req_lvl] == CW'(QUEUE_DEPTH)) begin
                     // Book the thinned count now; the moves below keep the head
                     count_in[req_lvl] = CW'(KEEP);
                     total_in          = total_ff - TW'(DROP);
                     state_in          = (KEEP > 1) ? ST_THIN_RD : ST_APPEND;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end
            end
         end
         ST_THIN_RD: begin
            mem_rd     = 1'b1;
            mem_offset = (SW + 1)'(k_ff) << 1;
            state_in   = ST_THIN_WR;
         end
         ST_THIN_WR: begin
            // Move item 2k down to slot k
            mem_wr     = 1'b1;
            mem_offset = (SW + 1)'(k_ff);
            mem_wdata  = mem_rdata;
            if (k_ff == SW'(KEEP - 1)) begin
               state_in = ST_APPEND;
            end else begin
               k_in     = k_ff + SW'(1);
               state_in = ST_THIN_RD;
            end
         end
         ST_APPEND: begin
            mem_wr           = 1'b1;
            mem_offset       = (SW + 1)'(count_ff[lvl_ff]);
            count_in[lvl_ff] = count_ff[lvl_ff] + CW'(1);
            total_in         = total_ff + TW'(1);
            state_in         = ST_IDLE;
         end
         ST_SCAN: begin
            if (remain_ff == '0 || total_ff == '0) begin
               state_in = ST_IDLE;
            end else if (count_ff[lvl_ff] == '0) begin
               lvl_in = lvl_ff - LW'(1);
            end else begin
               // Pop the head of this level
               mem_rd           = 1'b1;
               head_in[lvl_ff]  = (head_ff[lvl_ff] == SW'(QUEUE_DEPTH - 1)) ?
                                  '0 : head_ff[lvl_ff] + SW'(1);
               count_in[lvl_ff] = count_ff[lvl_ff] - CW'(1);
               total_in         = total_ff - TW'(1);
               remain_in        = remain_ff - MAXCNT_W'(1);
               state_in         = ST_READ;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = HANDLE_W'(mem_rdata);
               rsp_prio_in   = PRIO_W'(lvl_ff);
               rsp_last_in   = (remain_ff == '0) || (total_ff == '0);
               state_in      = rsp_last_in ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff        <= lvl_in;
      handle_ff     <= handle_in;
      remain_ff     <= remain_in;
      k_ff          <= k_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_last_ff   <= rsp_last_in;
   end

   spq_store #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .HANDLE_BITS     (HANDLE_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd),
      .wr_en   (mem_wr),
      .level   (lvl_ff),
      .head    (head_ff[lvl_ff]),
      .offset  (mem_offset),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sent_handle   = rsp_handle_ff;
   assign rsp_sent_priority = rsp_prio_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/core/spq_checker.sv
`default_nettype none

module spq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_opcode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [spq_pkg::HANDLE_W-1:0]  rsp_sent_handle,
   input wire logic [spq_pkg::PRIO_W-1:0]    rsp_sent_priority,
   input wire logic                          rsp_last
);

   import spq_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sent_handle)
         && $stable(rsp_sent_priority) && $stable(rsp_last))
      else $error("stalled result changed");

   // A send occupies the block, so ready drops behind it
   a_send_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == OP_SEND |=> !req_ready)
      else $error("ready stayed high after a send item");

   // A receive never starts a result
   a_recv_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == OP_RECEIVE |=> !$rose(rsp_valid))
      else $error("result appeared after a receive item");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind strict_priority_packet_queue spq_checker u_spq_checker (.*);

`default_nettype wire
